// File: design/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int WORD_W  = 32;
    localparam int BLOCK_W = 512;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_in;
        logic       step;
    } sched_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } round_ctl_t;

    localparam word_t [7:0] H_INIT = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// File: design/sha_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_sched
// Block buffer and message schedule window: message and pad bytes shift in,
// schedule words shift in during the rounds.
// ----------------------------------------------------------------------------
module sha_sched (
    input  logic                clk,
    input  sha_pkg::sched_ctl_t ctl,
    output sha_pkg::word_t      w_cur
);
    import sha_pkg::*;

    logic [BLOCK_W-1:0] win_reg;
    logic [BLOCK_W-1:0] win_next;
    word_t              w_new;

    // word j of the window sits at win_reg[511-32j -: 32]
    assign w_cur = win_reg[511:480];
    assign w_new = small_sigma1(win_reg[63:32]) + win_reg[223:192]
                 + small_sigma0(win_reg[479:448]) + win_reg[511:480];

    always_comb
    begin
        win_next = win_reg;
        if (ctl.load_byte)
        begin
            win_next = {win_reg[BLOCK_W-9:0], ctl.byte_in};
        end
        else if (ctl.step)
        begin
            win_next = {win_reg[BLOCK_W-WORD_W-1:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// File: design/sha_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_round
// Working variables a..h and the shared round datapath, one round a cycle.
// ----------------------------------------------------------------------------
module sha_round (
    input  logic                  clk,
    input  sha_pkg::round_ctl_t   ctl,
    input  sha_pkg::word_t [7:0]  hash_in,
    input  sha_pkg::word_t        k,
    input  sha_pkg::word_t        w,
    output sha_pkg::word_t [7:0]  vars
);
    import sha_pkg::*;

    word_t [7:0] var_reg;
    word_t [7:0] var_next;
    word_t       t1;
    word_t       t2;

    assign t1 = var_reg[7] + big_sigma1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6])) + k + w;
    assign t2 = big_sigma0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    always_comb
    begin
        var_next = var_reg;
        if (ctl.load)
        begin
            var_next = hash_in;
        end
        else if (ctl.step)
        begin
            var_next[7] = var_reg[6];
            var_next[6] = var_reg[5];
            var_next[5] = var_reg[4];
            var_next[4] = var_reg[3] + t1;
            var_next[3] = var_reg[2];
            var_next[2] = var_reg[1];
            var_next[1] = var_reg[0];
            var_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        var_reg <= var_next;
    end

    assign vars = var_reg;

endmodule

// File: design/sha256_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash
// SHA-256 over a byte stream with padding and digest output.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  input   | in_valid, in_stall, opcode, msg_byte      | item in
//  output  | out_valid, out_stall, digest_word,        | eight items per
//          | word_index, last_word                     | finish
//
// An absorb item is taken in S_IDLE; the 64th byte of a block also runs the
// 64 rounds of the shared round unit (S_ROUND), then the hash add (S_ADD).
// Finish shifts pad bytes one a cycle (64 - fill, plus 64 if fill >= 56),
// runs the rounds and the hash add for each final block, then shows eight words.
// Reset loads the initial hash values and clears the counters.
// in_stall is high whenever an item is in progress; out_stall holds the word.
module sha256_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [0:0]  opcode,
    input  logic [7:0]  msg_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bitcnt_reg, bitcnt_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  pos_reg, pos_next;
    logic        first_reg, first_next;
    logic        final_reg, final_next;
    logic        fin_reg, fin_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    word_t [7:0] hash_reg, hash_next;

    sched_ctl_t  sctl;
    round_ctl_t  rctl;
    word_t       w_cur;
    word_t [7:0] vars;
    logic [2:0]  len_sel;
    logic [7:0]  pad_byte;

    sha_sched u_sched (
        .clk   (clk),
        .ctl   (sctl),
        .w_cur (w_cur)
    );

    sha_round u_round (
        .clk     (clk),
        .ctl     (rctl),
        .hash_in (hash_reg),
        .k       (round_k(rnd_reg)),
        .w       (w_cur),
        .vars    (vars)
    );

    assign len_sel = 3'd7 - pos_reg[2:0];

    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = 8'h80;
        end
        else if (final_reg && (pos_reg >= 6'd56))
        begin
            pad_byte = len_reg[{len_sel, 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bitcnt_next = bitcnt_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        first_next  = first_reg;
        final_next  = final_reg;
        fin_next    = fin_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        hash_next   = hash_reg;
        sctl        = '0;
        rctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_ABSORB)
                    begin
                        sctl.load_byte = 1'b1;
                        sctl.byte_in   = msg_byte;
                        if (fill_reg == 6'd63)
                        begin
                            fill_next   = 6'd0;
                            bitcnt_next = bitcnt_reg + 64'd512;
                            fin_next    = 1'b0;
                            rctl.load   = 1'b1;
                            rnd_next    = 6'd0;
                            state_next  = S_ROUND;
                        end
                        else
                        begin
                            fill_next = fill_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        len_next   = bitcnt_reg + {55'd0, fill_reg, 3'b000};
                        pos_next   = fill_reg;
                        first_next = 1'b1;
                        final_next = (fill_reg < 6'd56);
                        fin_next   = 1'b1;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                sctl.load_byte = 1'b1;
                sctl.byte_in   = pad_byte;
                first_next     = 1'b0;
                pos_next       = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    rctl.load  = 1'b1;
                    rnd_next   = 6'd0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                sctl.step = 1'b1;
                rctl.step = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + vars[i];
                end
                if (!fin_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (final_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = S_OUT;
                end
                else
                begin
                    // length goes in a second, zero-filled block
                    pos_next   = 6'd0;
                    first_next = 1'b0;
                    final_next = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        hash_next   = H_INIT;
                        fill_next   = 6'd0;
                        bitcnt_next = 64'd0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= 6'd0;
            bitcnt_reg <= 64'd0;
            hash_reg   <= H_INIT;
            first_reg  <= 1'b0;
            final_reg  <= 1'b0;
            fin_reg    <= 1'b0;
            rnd_reg    <= 6'd0;
            idx_reg    <= 3'd0;
            pos_reg    <= 6'd0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bitcnt_reg <= bitcnt_next;
            hash_reg   <= hash_next;
            first_reg  <= first_next;
            final_reg  <= final_next;
            fin_reg    <= fin_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = hash_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

`ifndef NO_ASSERTIONS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_word) |=>
            (fill_reg == 6'd0 && bitcnt_reg == 64'd0 && state_reg == S_IDLE))
        else $error("counters not cleared after last digest word");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && rnd_reg == 6'd63) |=> (state_reg == S_ADD))
        else $error("round loop did not end after 64 rounds");

    a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == OP_ABSORB && fill_reg == 6'd63)
            |=> (state_reg == S_ROUND && rnd_reg == 6'd0))
        else $error("full block did not start compression");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hash testbench
// Drives absorb and finish items with random idling and stalls, predicts the
// eight digest words of every message and compares each output item in order.
// ----------------------------------------------------------------------------
module tb_top;
    import sha_pkg::*;

    localparam int   CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_item_t;

    typedef struct {
        logic        op;
        logic [7:0]  data;
        logic        has_digest;
        logic [31:0] digest0;
    } stim_row_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [0:0]  opcode;
    logic [7:0]  msg_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_hash dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .msg_byte(msg_byte),
        .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );

    // predictor state
    logic [31:0] hash_h [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] bits_done;

    digest_item_t expected_digest_q [$];
    int  fail_count = 0;
    int  cycle_count = 0;
    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;
    int  hold_cycles = 0;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t1, t2, ws;
        for (int q = 0; q < 16; q++)
            w[q] = {blk[4*q], blk[4*q+1], blk[4*q+2], blk[4*q+3]};
        for (int q = 0; q < 8; q++)
            v[q] = hash_h[q];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                ws = w[r];
            else
            begin
                ws = (ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10))
                   + w[(r-7)&15]
                   + (ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3))
                   + w[r&15];
                w[r&15] = ws;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + ws;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int q = 0; q < 8; q++)
            hash_h[q] += v[q];
    endtask

    task automatic hash_reset();
        for (int q = 0; q < 8; q++)
            hash_h[q] = IV[q];
        fill = 0;
        bits_done = '0;
    endtask

    task automatic predict_digest(logic op, logic [7:0] data);
        int i;
        logic [63:0] total;
        digest_item_t it;
        if (op == OP_ABSORB)
        begin
            blk[fill] = data;
            fill++;
            if (fill == 64)
            begin
                compress_blk();
                bits_done += 64'd512;
                fill = 0;
            end
            return;
        end
        i = fill;
        total = bits_done + 64'(i) * 8;
        blk[i] = 8'h80;
        i++;
        if (i > 56)
        begin
            while (i < 64) begin blk[i] = 8'h00; i++; end
            compress_blk();
            i = 0;
        end
        while (i < 56) begin blk[i] = 8'h00; i++; end
        for (int q = 0; q < 8; q++)
            blk[56+q] = total[63-8*q -: 8];
        compress_blk();
        for (int q = 0; q < 8; q++)
        begin
            it.word = hash_h[q];
            it.idx  = 3'(q);
            it.last = (q == 7);
            expected_digest_q.push_back(it);
        end
        hash_reset();
    endtask

    always
    begin
        clk = 1'b0; #2;
        clk = 1'b1; #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: stall pattern and long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off && hold_cycles < 3000)
        begin
            hold_cycles <= hold_cycles + 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // output checker
    always @(posedge clk)
    begin
        digest_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", digest_word);
                fail_count++;
            end
            else
            begin
                e = expected_digest_q.pop_front();
                if (digest_word !== e.word)
                begin
                    $error("digest_word expected %h actual %h", e.word, digest_word);
                    fail_count++;
                end
                if (word_index !== e.idx)
                begin
                    $error("word_index expected %0d actual %0d", e.idx, word_index);
                    fail_count++;
                end
                if (last_word !== e.last)
                begin
                    $error("last_word expected %0d actual %0d", e.last, last_word);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(logic op, logic [7:0] data);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        msg_byte <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digest(op, data);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_digest_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(int len);
        for (int j = 0; j < len; j++)
            send_item(OP_ABSORB, 8'($urandom_range(255)));
        send_item(OP_FINISH, 8'($urandom_range(255)));
    endtask

    stim_row_t directed [] = '{
        '{OP_FINISH, 8'h00, 1'b1, 32'he3b0c442},  // empty message right after reset
        '{OP_FINISH, 8'hff, 1'b1, 32'he3b0c442},  // empty again, byte ignored
        '{OP_ABSORB, 8'h61, 1'b0, 32'h0},
        '{OP_ABSORB, 8'h62, 1'b0, 32'h0},
        '{OP_ABSORB, 8'h63, 1'b0, 32'h0},
        '{OP_FINISH, 8'h00, 1'b1, 32'hba7816bf},  // "abc"
        '{OP_ABSORB, 8'h00, 1'b0, 32'h0},
        '{OP_FINISH, 8'h00, 1'b0, 32'h0},
        '{OP_ABSORB, 8'hff, 1'b0, 32'h0},
        '{OP_FINISH, 8'h00, 1'b0, 32'h0},
        '{OP_ABSORB, 8'h55, 1'b0, 32'h0},
        '{OP_ABSORB, 8'haa, 1'b0, 32'h0},
        '{OP_FINISH, 8'h00, 1'b0, 32'h0}
    };

    initial
    begin
        int mode;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        opcode   = OP_ABSORB;
        msg_byte = 8'h00;
        hash_reset();
        for (int q = 0; q < 64; q++)
            blk[q] = 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            if (directed[n].has_digest)
                drain();
            send_item(directed[n].op, directed[n].data);
            if (directed[n].has_digest && expected_digest_q[0].word !== directed[n].digest0)
            begin
                $error("digest_word expected %h actual %h",
                       directed[n].digest0, expected_digest_q[0].word);
                fail_count++;
            end
        end
        // padding edges: 55, 56, 63 and 64 bytes
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        drain();

        // long hold-off while items keep coming
        hold_off = 1;
        send_message(3);
        send_message(1);
        send_message(0);
        drain();
        hold_off = 0;

        for (int ph = 0; ph < 4; ph++)
        begin
            mode = ph;
            sender_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 86 : 17) : 0;
            recv_stall_pct  = (mode == 2 || mode == 3) ? ((mode == 2) ? 86 : 17) : 0;
            for (int m = 0; m < 2; m++)
                send_message(($urandom_range(9) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(0, 8));
            drain();  // sender pauses until all digests arrive
        end

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
